[design/msrt_pkg.sv]
// ----------------------------------------------------------------------------
// msrt_pkg
// Shared types and constants for the systolic merge sorter.
// ----------------------------------------------------------------------------
package msrt_pkg;

  localparam int VALUE_W = 32;

  typedef logic signed [VALUE_W-1:0] value_t;

  // What one cell shows its neighbors.
  typedef struct packed {
    logic   valid;
    logic   gt;     // the cell is empty or holds a value greater than the item being inserted
    value_t value;
  } cell_link_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic ins;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } msrt_state_t;

endpackage

[design/msrt_if.sv]
// ----------------------------------------------------------------------------
// msrt_if
// Valid/ready channels for the sorter's input items and result items.
// ----------------------------------------------------------------------------
interface msrt_in_if import msrt_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t value;
  logic   last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface msrt_out_if import msrt_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t sorted_value;
  logic   end_of_run;
  logic   overflow;

  modport source (output valid, output sorted_value, output end_of_run,
                  output overflow, input ready);
  modport sink   (input valid, input sorted_value, input end_of_run,
                  input overflow, output ready);
endinterface

[design/msrt_cell.sv]
// ----------------------------------------------------------------------------
// msrt_cell
// One slot of the sorting chain: holds a value, makes room for an inserted
// item by taking its left neighbor, and shifts left while the run drains.
// ----------------------------------------------------------------------------
module msrt_cell import msrt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  value_t     in_value,
  input  cell_link_t left_link,
  input  cell_link_t right_link,
  output cell_link_t link
);

  value_t value_r, value_nxt;
  logic   valid_r, valid_nxt;
  logic   gt;

  // Empty cells count as greater, so the set stays packed to the left.
  assign gt   = !valid_r || (in_value < value_r);
  assign link = '{valid: valid_r, gt: gt, value: value_r};

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (ctrl.shift) begin
      value_nxt = right_link.value;
      valid_nxt = right_link.valid;
    end else if (ctrl.ins && gt) begin
      if (left_link.gt) begin
        value_nxt = left_link.value;
        valid_nxt = left_link.valid;
      end else begin
        value_nxt = in_value;
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

[design/merge_sorter.sv]
// ----------------------------------------------------------------------------
// merge_sorter
// Sorts a set of signed values in ascending order on a chain of cells.
// ----------------------------------------------------------------------------
// Items are loaded one per cycle; each is inserted into a row of MAX_ITEMS
// cells that always stays sorted. After the item marked last is taken, the
// results follow from the head of the chain, starting in the very next cycle,
// at one per cycle whenever out_ch.ready is high, and the whole row shifts
// left by one cell for each result taken. No input is taken while a run is
// being emitted. Items beyond MAX_ITEMS are dropped and every result of that
// run has overflow set.
module merge_sorter import msrt_pkg::*; #(
  parameter int MAX_ITEMS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  msrt_in_if.sink     in_ch,
  msrt_out_if.source  out_ch
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  msrt_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             dropped_r, dropped_nxt;
  logic             in_acc, out_acc, full;
  cell_ctrl_t       ctrl;
  cell_link_t       links [MAX_ITEMS];

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign full    = (count_r == CNT_W'(MAX_ITEMS));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: if (in_acc && in_ch.last) state_nxt = ST_EMIT;
      ST_EMIT: if (out_acc && count_r == CNT_W'(1)) state_nxt = ST_LOAD;
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Outputs and datapath control
  always_comb begin
    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;
    ctrl         = '0;
    count_nxt    = count_r;
    dropped_nxt  = dropped_r;
    case (state_r)
      ST_LOAD: begin
        in_ch.ready = 1'b1;
        if (in_acc) begin
          if (full) begin
            dropped_nxt = 1'b1;
          end else begin
            ctrl.ins  = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
        end
      end
      ST_EMIT: begin
        out_ch.valid = 1'b1;
        if (out_acc) begin
          ctrl.shift = 1'b1;
          count_nxt  = count_r - CNT_W'(1);
          if (count_r == CNT_W'(1)) dropped_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.sorted_value = links[0].value;
  assign out_ch.end_of_run   = (count_r == CNT_W'(1));
  assign out_ch.overflow     = dropped_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      count_r   <= '0;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    cell_link_t left_l, right_l;

    if (i == 0) begin : g_head
      assign left_l = '{valid: 1'b0, gt: 1'b0, value: '0};
    end else begin : g_mid
      assign left_l = links[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign right_l = '{valid: 1'b0, gt: 1'b1, value: '0};
    end else begin : g_body
      assign right_l = links[i+1];
    end

    msrt_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .in_value   (in_ch.value),
      .left_link  (left_l),
      .right_link (right_l),
      .link       (links[i])
    );
  end

`ifndef SYNTHESIS
  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (count_r != '0) && links[0].valid)
    else $error("result offered from an empty chain");

  a_drop_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && full) |=> dropped_r)
    else $error("dropped item not flagged");

  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_ch.end_of_run) |=> in_ch.ready && !dropped_r && !links[0].valid)
    else $error("chain not empty after the end of a run");

  a_no_count_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ITEMS))
    else $error("item count beyond capacity");
`endif

endmodule
